### rtl/core/pdcw_pkg.sv
// Shared constants and types for the PWM duty coalescing writer.
package pdcw_pkg;

    localparam int MAX_CHANNELS       = 16;
    localparam int DEF_CHANNEL_COUNT  = 16;
    localparam int DEF_FIRST_LED_REG  = 6;
    localparam int CH_W               = 4;
    localparam int DUTY_W             = 16;
    localparam int CNT_W              = 13;
    localparam int PHASE_W            = 12;
    localparam int ADDR_W             = 8;
    localparam int IN_TDATA_W         = 24;
    localparam int OUT_TDATA_W        = 40;

    localparam logic MODE_SET   = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    localparam logic [CNT_W-1:0] FULL_SCALE = 13'h1000;

    typedef struct packed {
        logic                    start;
        logic [MAX_CHANNELS-1:0] mask;
    } t_flush_req;

endpackage

### rtl/core/pdcw_ram.sv
// Generic single-write, single-read RAM with registered, enabled read.
module pdcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/pdcw_flush.sv
// Flush sequencer: walks pending channels, reads duty, formats register writes.
module pdcw_flush
    import pdcw_pkg::*;
#(
    parameter int CHANNEL_COUNT      = DEF_CHANNEL_COUNT,
    parameter int FIRST_LED_REGISTER = DEF_FIRST_LED_REG,
    localparam int AW                = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_flush_req             i_req,
    output logic                   o_busy,
    output logic                   o_rd_en,
    output logic [AW-1:0]          o_rd_addr,
    input  logic [DUTY_W-1:0]      i_rd_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [OUT_TDATA_W-1:0] o_data,
    output logic                   o_last
);

    logic [CHANNEL_COUNT-1:0] r_pend, n_pend;
    logic [CHANNEL_COUNT-1:0] pick_bit;
    logic [CH_W-1:0]          pick_ch;
    logic                     issue, load;

    logic            r_rd_vld;
    logic [CH_W-1:0] r_rd_ch;
    logic            r_rd_last;

    logic               r_out_vld;
    logic [ADDR_W-1:0]  r_addr;
    logic [CH_W-1:0]    r_ch;
    logic [CNT_W-1:0]   r_on;
    logic [CNT_W-1:0]   r_off;
    logic               r_last;

    logic [ADDR_W-1:0]  c_addr;
    logic [CNT_W-1:0]   c_on, c_off;
    logic [PHASE_W-1:0] phase;

    always_comb begin
        pick_ch  = '0;
        pick_bit = '0;
        for (int i = CHANNEL_COUNT - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                pick_ch  = CH_W'(i);
                pick_bit = '0;
                pick_bit[i] = 1'b1;
            end
        end
    end

    assign load  = r_rd_vld && (!r_out_vld || i_ready);
    assign issue = (r_pend != '0) && (!r_rd_vld || load);

    always_comb begin
        n_pend = r_pend;
        if (i_req.start) begin
            n_pend = i_req.mask[CHANNEL_COUNT-1:0];
        end else if (issue) begin
            n_pend = r_pend & ~pick_bit;
        end
    end

    assign o_busy    = (r_pend != '0);
    assign o_rd_en   = issue;
    assign o_rd_addr = pick_ch[AW-1:0];

    // duty >= full scale: full on; zero: full off; else staggered edge
    assign phase  = {r_rd_ch, 8'h00};
    assign c_addr = ADDR_W'(FIRST_LED_REGISTER) + {2'b00, r_rd_ch, 2'b00};
    always_comb begin
        if (i_rd_data[DUTY_W-1:PHASE_W] != '0) begin
            c_on  = FULL_SCALE;
            c_off = '0;
        end else if (i_rd_data == '0) begin
            c_on  = '0;
            c_off = FULL_SCALE;
        end else begin
            c_on  = {1'b0, phase};
            c_off = {1'b0, i_rd_data[PHASE_W-1:0] + phase};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (issue) begin
                r_rd_vld <= 1'b1;
            end else if (load) begin
                r_rd_vld <= 1'b0;
            end
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_ch   <= pick_ch;
            r_rd_last <= ((r_pend & ~pick_bit) == '0);
        end
        if (load) begin
            r_addr <= c_addr;
            r_ch   <= r_rd_ch;
            r_on   <= c_on;
            r_off  <= c_off;
            r_last <= r_rd_last;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = {2'b00, r_off, r_on, r_ch, r_addr};
    assign o_last  = r_last;

endmodule

### rtl/core/pwm_duty_coalescing_writer_top.sv
// Top level of the PWM duty coalescing writer.
// A set beat (tuser 0) stores a channel's duty and marks it dirty;
// channels at or above CHANNEL_COUNT are dropped. A flush beat (tuser 1) takes
// a snapshot of the dirty marks and clears them; the flush sequencer then
// reads the duty RAM once per pending channel in ascending order and, while
// m_axis_tready is high, emits one register write per cycle, the final one
// flagged with tlast. Throughput is one set beat per cycle outside a flush
// and one output beat per cycle during a flush with m_axis_tready high,
// set by the single read port of the duty RAM. Input is held off while
// channel reads remain to be issued. A flush with nothing dirty gives no output.
module pwm_duty_coalescing_writer_top
    import pdcw_pkg::*;
#(
    parameter int CHANNEL_COUNT      = DEF_CHANNEL_COUNT,
    parameter int FIRST_LED_REGISTER = DEF_FIRST_LED_REG
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [3:0] channel, [19:4] duty_count, [23:20] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] mode
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] register_address, [11:8] out_channel, [24:12] on_count,
    // [37:25] off_count, [39:38] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);

    localparam int AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    logic [CHANNEL_COUNT-1:0] r_dirty, n_dirty;
    logic                     accept, in_range, set_we;
    logic [CH_W-1:0]          in_ch;
    logic [DUTY_W-1:0]        in_duty;
    logic                     busy;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic [DUTY_W-1:0]        rd_data;
    t_flush_req               req;

    assign in_ch    = s_axis_tdata[CH_W-1:0];
    assign in_duty  = s_axis_tdata[CH_W+DUTY_W-1:CH_W];
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign in_range = ({1'b0, in_ch} < (CH_W+1)'(CHANNEL_COUNT));
    assign set_we   = accept && (s_axis_tuser == MODE_SET) && in_range;

    assign s_axis_tready = i_rst_n && !busy;

    always_comb begin
        req.start = accept && (s_axis_tuser == MODE_FLUSH);
        req.mask  = '0;
        req.mask[CHANNEL_COUNT-1:0] = r_dirty;
    end

    always_comb begin
        n_dirty = r_dirty;
        if (req.start) begin
            n_dirty = '0;
        end else if (set_we) begin
            n_dirty[in_ch[AW-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty <= '0;
        end else begin
            r_dirty <= n_dirty;
        end
    end

    pdcw_ram #(
        .WIDTH (DUTY_W),
        .DEPTH (CHANNEL_COUNT)
    ) u_duty_ram (
        .i_clk   (i_clk),
        .i_we    (set_we),
        .i_waddr (in_ch[AW-1:0]),
        .i_wdata (in_duty),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    pdcw_flush #(
        .CHANNEL_COUNT      (CHANNEL_COUNT),
        .FIRST_LED_REGISTER (FIRST_LED_REGISTER)
    ) u_flush (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .o_busy    (busy),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

endmodule
